FILE: rtl/line_request_coalescing_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line request coalescing table
// Clocked, reset-gated property wrappers used by the top-level table module.
// ----------------------------------------------------------------------------
`ifndef LINE_REQUEST_COALESCING_TABLE_ASSERT_SVH
`define LINE_REQUEST_COALESCING_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LRCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lrct assertion failed");

// antecedent implies consequent in the next cycle
`define LRCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lrct assertion failed");

`endif

FILE: rtl/lrct_pkg.sv
// ----------------------------------------------------------------------------
// lrct_pkg
// Types, codes and defaults shared by the coalescing table modules.
// ----------------------------------------------------------------------------
package lrct_pkg;

	localparam int LINE_SLOTS_DEF     = 16;
	localparam int WORDS_PER_LINE_DEF = 8;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_DRAIN = 2'd1;

	localparam logic [2:0] ST_ADDED       = 3'd0;
	localparam logic [2:0] ST_NO_LINE     = 3'd1;
	localparam logic [2:0] ST_WORDS_FULL  = 3'd2;
	localparam logic [2:0] ST_DRAINED     = 3'd3;
	localparam logic [2:0] ST_DRAIN_MISS  = 3'd4;
	localparam logic [2:0] ST_CLEARED     = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [47:0] line_address;
		logic [15:0] iteration;
		logic [15:0] word_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] entry_iteration;
		logic [15:0] entry_word;
		logic        last;
		logic        table_full;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DRAIN = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [47:0] line_address;
		logic [15:0] iteration;
		logic [15:0] word_id;
	} cmd_t;

endpackage

FILE: rtl/lrct_front.sv
// ----------------------------------------------------------------------------
// lrct_front
// Accepts request words, decodes the action and queues commands for the back.
// ----------------------------------------------------------------------------
module lrct_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lrct_pkg::req_t req,
	output logic           cmd_valid,
	input  logic           cmd_pop,
	output lrct_pkg::cmd_t cmd
);
	import lrct_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          queue_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	cmd_t          cmd_in;
	logic          push;
	logic          pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + PW'(1);
		return r;
	endfunction

	// high action bit means clear, the unused code included
	always_comb begin
		cmd_in.line_address = req.line_address;
		cmd_in.iteration    = req.iteration;
		cmd_in.word_id      = req.word_id;
		if (req.action[1])
			cmd_in.op = OP_CLEAR;
		else if (req.action == ACT_DRAIN)
			cmd_in.op = OP_DRAIN;
		else
			cmd_in.op = OP_ADD;
	end

	assign req_ready = (count_q != CW'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= cmd_in;
	end

endmodule

FILE: rtl/lrct_back.sv
// ----------------------------------------------------------------------------
// lrct_back
// Line lookup, word slot allocation, drain sequencing and the result register.
// ----------------------------------------------------------------------------
module lrct_back #(
	parameter int LINE_SLOTS     = lrct_pkg::LINE_SLOTS_DEF,
	parameter int WORDS_PER_LINE = lrct_pkg::WORDS_PER_LINE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  lrct_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lrct_pkg::rsp_t rsp
);
	import lrct_pkg::*;

	localparam int LW    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int WW    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam int DEPTH = LINE_SLOTS * WORDS_PER_LINE;
	localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic [15:0] iteration;
		logic [15:0] word;
	} slot_t;

	state_t                    state_q;
	logic [LINE_SLOTS-1:0]     line_valid_q;
	logic [47:0]               tag_q [LINE_SLOTS];
	logic [WORDS_PER_LINE-1:0] words_q [LINE_SLOTS];
	logic [LW-1:0]             drain_line_q;
	logic [WORDS_PER_LINE-1:0] drain_mask_q;
	slot_t                     mem [DEPTH];
	slot_t                     rd_data_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	logic [LINE_SLOTS-1:0]     hit_vec;
	logic                      hit;
	logic [LW-1:0]             hit_idx;
	logic                      has_free;
	logic [LW-1:0]             free_idx;
	logic                      all_valid;
	logic [LW-1:0]             line_sel;
	logic [WORDS_PER_LINE-1:0] row;
	logic                      has_word;
	logic [WW-1:0]             word_idx;
	logic [LINE_SLOTS-1:0]     claim_vec;
	logic [WW-1:0]             drain_j;
	logic [WORDS_PER_LINE-1:0] drain_rest;
	logic                      out_free;
	logic                      go;
	logic                      add_ok;
	logic                      emit;
	rsp_t                      rsp_next;
	logic                      rd_en;
	logic [SAW-1:0]            rd_addr;
	logic [SAW-1:0]            wr_addr;

	function automatic logic [LW-1:0] low_line(input logic [LINE_SLOTS-1:0] v);
		logic [LW-1:0] r;
		r = '0;
		for (int i = LINE_SLOTS - 1; i >= 0; i--)
			if (v[i])
				r = LW'(i);
		return r;
	endfunction

	function automatic logic [WW-1:0] low_word(input logic [WORDS_PER_LINE-1:0] v);
		logic [WW-1:0] r;
		r = '0;
		for (int i = WORDS_PER_LINE - 1; i >= 0; i--)
			if (v[i])
				r = WW'(i);
		return r;
	endfunction

	function automatic logic [SAW-1:0] slot_index(input logic [LW-1:0] l,
			input logic [WW-1:0] j);
		return SAW'(32'(l) * WORDS_PER_LINE + 32'(j));
	endfunction

	always_comb begin
		for (int i = 0; i < LINE_SLOTS; i++)
			hit_vec[i] = line_valid_q[i] && (tag_q[i] == cmd.line_address);
	end

	assign hit        = |hit_vec;
	assign hit_idx    = low_line(hit_vec);
	assign has_free   = ~&line_valid_q;
	assign free_idx   = low_line(~line_valid_q);
	assign all_valid  = &line_valid_q;
	assign line_sel   = hit ? hit_idx : free_idx;
	// a freshly claimed line has no words
	assign row        = hit ? words_q[hit_idx] : '0;
	assign has_word   = ~&row;
	assign word_idx   = low_word(~row);
	assign claim_vec  = line_valid_q | (LINE_SLOTS'(1) << line_sel);
	assign drain_j    = low_word(drain_mask_q);
	assign drain_rest = drain_mask_q & ~(WORDS_PER_LINE'(1) << drain_j);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign go         = (state_q == S_IDLE) && cmd_valid && out_free;
	assign add_ok     = go && (cmd.op == OP_ADD) && (hit || has_free) && has_word;
	assign cmd_pop    = go;
	assign rd_addr    = slot_index(drain_line_q, drain_j);
	assign wr_addr    = slot_index(line_sel, word_idx);

	always_comb begin
		emit     = 1'b0;
		rd_en    = 1'b0;
		rsp_next = '0;
		unique case (state_q)
			S_IDLE: begin
				if (go) begin
					rsp_next.last = 1'b1;
					unique case (cmd.op)
						OP_ADD: begin
							emit = 1'b1;
							if (!hit && !has_free) begin
								rsp_next.status     = ST_NO_LINE;
								rsp_next.table_full = all_valid;
							end else if (!has_word) begin
								rsp_next.status     = ST_WORDS_FULL;
								rsp_next.table_full = all_valid;
							end else begin
								rsp_next.status     = ST_ADDED;
								rsp_next.table_full = &claim_vec;
							end
						end
						OP_DRAIN: begin
							if (!hit) begin
								emit                = 1'b1;
								rsp_next.status     = ST_DRAIN_MISS;
								rsp_next.table_full = all_valid;
							end else if (row == '0) begin
								emit            = 1'b1;
								rsp_next.status = ST_DRAIN_MISS;
							end
						end
						OP_CLEAR: begin
							emit            = 1'b1;
							rsp_next.status = ST_CLEARED;
						end
						default: ;
					endcase
				end
			end
			S_READ: rd_en = 1'b1;
			S_EMIT: begin
				if (out_free) begin
					emit                     = 1'b1;
					rsp_next.status          = ST_DRAINED;
					rsp_next.entry_iteration = rd_data_q.iteration;
					rsp_next.entry_word      = rd_data_q.word;
					rsp_next.last            = (drain_rest == '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			line_valid_q <= '0;
			drain_line_q <= '0;
			drain_mask_q <= '0;
			rsp_valid_q  <= 1'b0;
			for (int i = 0; i < LINE_SLOTS; i++)
				words_q[i] <= '0;
		end else begin
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						if (add_ok) begin
							line_valid_q[line_sel]       <= 1'b1;
							words_q[line_sel][word_idx] <= 1'b1;
						end
						if (cmd.op == OP_DRAIN && hit) begin
							// line is freed up front; the mask drives the word sweep
							line_valid_q[hit_idx] <= 1'b0;
							words_q[hit_idx]      <= '0;
							drain_line_q          <= hit_idx;
							drain_mask_q          <= row;
							if (row != '0)
								state_q <= S_READ;
						end
						if (cmd.op == OP_CLEAR) begin
							line_valid_q <= '0;
							for (int i = 0; i < LINE_SLOTS; i++)
								words_q[i] <= '0;
						end
					end
				end
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						drain_mask_q <= drain_rest;
						state_q      <= (drain_rest == '0) ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (add_ok && !hit)
			tag_q[free_idx] <= cmd.line_address;
		if (emit)
			rsp_q <= rsp_next;
	end

	always_ff @(posedge clk) begin
		if (add_ok)
			mem[wr_addr] <= '{iteration: cmd.iteration, word: cmd.word_id};
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/line_request_coalescing_table.sv
// ----------------------------------------------------------------------------
// line_request_coalescing_table
// Coalesces word requests by cache-line address and drains them per line.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one request word: add, drain or clear.
//   rsp (valid/ready) carries result words; each request yields exactly one,
//   except a drain hit, which yields one per stored word, last on the final.
//   A two-entry command queue sits between the request side and the table
//   engine, and a result register sits at the output.
//   An add, clear or drain miss passes the command queue and then the result
//   register. A drain of n words leaves the idle state, then takes a read state
//   of the word memory and an emit state that registers the result per word.
//   Throughput: adds and clears run one per cycle unless the output stalls.
//   Reset clears the line and word valid bits, queue pointers and result valid
//   flag; tags, word data, queue slots and the result word are not reset.
//   When rsp_ready is low a held result stays in its register, the engine waits,
//   and requests keep entering until the queue is full.
// ----------------------------------------------------------------------------
`include "line_request_coalescing_table_assert.svh"

module line_request_coalescing_table #(
	parameter int LINE_SLOTS     = lrct_pkg::LINE_SLOTS_DEF,
	parameter int WORDS_PER_LINE = lrct_pkg::WORDS_PER_LINE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lrct_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lrct_pkg::rsp_t rsp
);
	import lrct_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	logic rsp_frees;

	lrct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	lrct_back #(
		.LINE_SLOTS     (LINE_SLOTS),
		.WORDS_PER_LINE (WORDS_PER_LINE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// drained and cleared words always leave at least one line free
	assign rsp_frees = (rsp.status == ST_DRAINED) || (rsp.status == ST_CLEARED);

	`LRCT_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, cmd_pop, cmd_valid)
	`LRCT_ASSERT_IMPL(a_ready_only_full, clk, arst_n, !req_ready, cmd_valid)
	`LRCT_ASSERT_IMPL(a_not_last_is_drain, clk, arst_n, rsp_valid && !rsp.last, rsp.status == ST_DRAINED)
	`LRCT_ASSERT_IMPL(a_freed_not_full, clk, arst_n, rsp_valid && rsp_frees, !rsp.table_full)

endmodule

FILE: tb/sv/lrct_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_result_checker
// Watches both channels of the coalescing table. Keeps its own copy of the
// line and word slots, works out the result words each accepted request must
// produce, and compares every accepted result word against the oldest one due.
// ----------------------------------------------------------------------------
module lrct_result_checker
	import lrct_pkg::*;
#(
	parameter int LINES = LINE_SLOTS_DEF,
	parameter int WORDS = WORDS_PER_LINE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   results_due,
	output int   mismatches
);

	bit [47:0] line_tag_copy [LINES];
	bit        line_busy     [LINES];
	bit [15:0] held_iter     [LINES*WORDS];
	bit [15:0] held_word     [LINES*WORDS];
	bit        held_busy     [LINES*WORDS];

	rsp_t due_results[$];
	rsp_t want;

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] exp_val);
		mismatches++;
		$display("%0t lrct check: %s got %0h want %0h", $realtime, what, got, exp_val);
	endtask

	function automatic rsp_t make_word(input logic [2:0] st, input bit [15:0] it,
			input bit [15:0] wd, input bit lst);
		rsp_t w;
		w.status          = st;
		w.entry_iteration = it;
		w.entry_word      = wd;
		w.last            = lst;
		w.table_full      = 1'b0;
		return w;
	endfunction

	// advances the slot copy by one request and queues the words it yields
	function automatic void apply_request(input req_t r);
		rsp_t batch[$];
		int   hit;
		int   free_line;
		int   s;
		bit   stored;
		bit   full;
		hit = -1;
		for (int i = 0; i < LINES; i++)
			if (hit < 0 && line_busy[i] && line_tag_copy[i] == r.line_address)
				hit = i;
		if (r.action[1]) begin
			// both clear codes decode on the high bit
			for (int i = 0; i < LINES; i++)
				line_busy[i] = 1'b0;
			for (int i = 0; i < LINES*WORDS; i++)
				held_busy[i] = 1'b0;
			batch.insert(batch.size(), make_word(ST_CLEARED, '0, '0, 1'b1));
		end else if (r.action == ACT_ADD) begin
			if (hit < 0) begin
				free_line = -1;
				for (int i = 0; i < LINES; i++)
					if (free_line < 0 && !line_busy[i])
						free_line = i;
				if (free_line >= 0) begin
					line_tag_copy[free_line] = r.line_address;
					line_busy[free_line]     = 1'b1;
					hit = free_line;
				end
			end
			if (hit < 0) begin
				batch.insert(batch.size(), make_word(ST_NO_LINE, '0, '0, 1'b1));
			end else begin
				stored = 1'b0;
				for (int j = 0; j < WORDS; j++) begin
					s = hit*WORDS + j;
					if (!stored && !held_busy[s]) begin
						held_iter[s] = r.iteration;
						held_word[s] = r.word_id;
						held_busy[s] = 1'b1;
						stored = 1'b1;
					end
				end
				batch.insert(batch.size(),
					make_word(stored ? ST_ADDED : ST_WORDS_FULL, '0, '0, 1'b1));
			end
		end else begin
			if (hit >= 0) begin
				for (int j = 0; j < WORDS; j++) begin
					s = hit*WORDS + j;
					if (held_busy[s]) begin
						batch.insert(batch.size(),
							make_word(ST_DRAINED, held_iter[s], held_word[s], 1'b0));
						held_busy[s] = 1'b0;
					end
				end
				line_busy[hit] = 1'b0;
			end
			// a line with no words drains like a miss
			if (batch.size() == 0)
				batch.insert(batch.size(), make_word(ST_DRAIN_MISS, '0, '0, 1'b1));
			else
				batch[batch.size()-1].last = 1'b1;
		end
		full = 1'b1;
		for (int i = 0; i < LINES; i++)
			if (!line_busy[i])
				full = 1'b0;
		foreach (batch[k]) begin
			batch[k].table_full = full;
			due_results.insert(due_results.size(), batch[k]);
		end
	endfunction

	initial begin
		mismatches  = 0;
		results_due = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++)
				line_busy[i] = 1'b0;
			for (int i = 0; i < LINES*WORDS; i++)
				held_busy[i] = 1'b0;
			due_results.delete();
			results_due <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result word with nothing due", 48'(rsp), '0);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 48'(rsp.status), 48'(want.status));
					if (rsp.entry_iteration !== want.entry_iteration)
						report_mismatch("entry_iteration", 48'(rsp.entry_iteration),
							48'(want.entry_iteration));
					if (rsp.entry_word !== want.entry_word)
						report_mismatch("entry_word", 48'(rsp.entry_word),
							48'(want.entry_word));
					if (rsp.last !== want.last)
						report_mismatch("last", 48'(rsp.last), 48'(want.last));
					if (rsp.table_full !== want.table_full)
						report_mismatch("table_full", 48'(rsp.table_full),
							48'(want.table_full));
				end
			end
			if (req_valid && req_ready)
				apply_request(req);
			results_due <= due_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add, drain and clear requests into the coalescing table: a directed
// pass over the corner cases, then phases of random traffic on a small pool of
// line addresses, with random gaps and stalls, a long result hold-off and a
// full pause. The checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module tb_top;
	import lrct_pkg::*;

	localparam logic [1:0] ACT_SPARE  = 2'd3;
	localparam int         CYCLE_CAP  = 400000;
	localparam int         HOLD_LEN   = 200;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   results_due;
	int   mismatches;

	bit src_idle;
	bit sink_idle;
	bit hold_ask;

	line_request_coalescing_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lrct_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.results_due (results_due),
		.mismatches  (mismatches)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic put_word(input logic [1:0] act, input logic [47:0] addr,
			input logic [15:0] it, input logic [15:0] wd);
		req_t w;
		w.action       = act;
		w.line_address = addr;
		w.iteration    = it;
		w.word_id      = wd;
		if (src_idle && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// stop offering and let every due result word come out
	task automatic drain_out();
		req_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// result side: random stalls, plus the long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				rsp_ready <= 1'b0;
				for (int n = 0; n < HOLD_LEN; n++) @(posedge clk);
				hold_done = 1'b1;
				rsp_ready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 6) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		for (int n = 0; n < CYCLE_CAP; n++) @(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		logic [47:0] pool[24];
		logic [47:0] addr;
		int          pool_size;
		int          pick;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		hold_ask  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases: both clear codes, miss on empty, table full,
		// no free line, word slots full, full-line drain
		put_word(OP_CLEAR, '0, '0, '0);
		put_word(ACT_SPARE, '1, '1, '1);
		put_word(OP_DRAIN, '0, '0, '0);
		for (int i = 0; i < 16; i++) begin
			addr = (i == 15) ? '1 : 48'(i) << 6;
			if (i == 0)
				put_word(OP_ADD, addr, 16'h0000, 16'h0000);
			else if (i == 15)
				put_word(OP_ADD, addr, 16'hffff, 16'hffff);
			else
				put_word(OP_ADD, addr, 16'($urandom), 16'($urandom));
		end
		put_word(OP_ADD, 48'h5555_5555_5555, 16'h1234, 16'h4321);
		for (int i = 0; i < 7; i++)
			put_word(OP_ADD, '1, 16'($urandom), 16'($urandom));
		put_word(OP_ADD, '1, 16'h0f0f, 16'hf0f0);
		put_word(OP_DRAIN, 48'h5555_5555_5555, '0, '0);
		put_word(OP_DRAIN, '1, '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			src_idle  = (phase % 2) == 0;
			sink_idle = (phase % 2) == 0;
			pool_size = $urandom_range(12, 24);
			for (int i = 0; i < pool_size; i++)
				pool[i] = 48'({$urandom, $urandom});
			if (phase == 1)
				drain_out();
			for (int k = 0; k < 85; k++) begin
				if (phase == 0 && k == 30)
					hold_ask = 1'b1;
				addr = pool[$urandom_range(0, pool_size - 1)];
				pick = $urandom_range(0, 99);
				if (pick < 62)
					put_word(OP_ADD, addr, 16'($urandom), 16'($urandom));
				else if (pick < 88)
					put_word(OP_DRAIN, addr, 16'($urandom), 16'($urandom));
				else if (pick < 92)
					put_word(pick[0] ? OP_ADD : OP_DRAIN, 48'({$urandom, $urandom}),
						16'($urandom), 16'($urandom));
				else if (pick < 94)
					put_word(OP_CLEAR, addr, 16'($urandom), 16'($urandom));
				else if (pick < 95)
					put_word(ACT_SPARE, addr, 16'($urandom), 16'($urandom));
				else
					put_word(OP_ADD, addr, 16'hffff, 16'h0000);
			end
		end

		drain_out();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
